### hdl/rzt_pkg.sv
// Shared widths, constants and register indexes of the rolling z-score trader.
package rzt_pkg;

  localparam int unsigned PRICE_W    = 24;
  localparam int unsigned TIME_W     = 63;
  localparam int unsigned QTY_W      = 24;
  localparam int unsigned PROFIT_W   = 64;
  localparam int unsigned WLEN_W     = 9;
  localparam int unsigned THR_W      = 16;
  localparam int unsigned HOLD_W     = 32;
  localparam int unsigned NS_W       = 30;

  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 32;

  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_LENGTH = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ENTRY_THR     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_EXIT_THR      = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_HOLD      = 2'd3;

  localparam logic [WLEN_W-1:0]  WINDOW_LENGTH_RST = 9'd20;
  localparam logic [THR_W-1:0]   ENTRY_THR_RST     = 16'd512;
  localparam logic [THR_W-1:0]   EXIT_THR_RST      = 16'd128;
  localparam logic [HOLD_W-1:0]  MAX_HOLD_RST      = 32'd60;

  localparam int unsigned MAX_WINDOW_DEF = 256;

  localparam logic [NS_W-1:0]    NS_PER_S   = 30'd1000000000;
  localparam logic [PRICE_W-1:0] QTY_BUDGET = 24'd10000000;

endpackage

### hdl/rzt_stream_if.sv
// Record and trade channels of the rolling z-score trader.
interface rzt_in_if;
  import rzt_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [PRICE_W-1:0]   price_milli;
  logic [TIME_W-1:0]    time_ns;
  logic                 segment_first;
  logic                 segment_last;
  modport source (output valid, price_milli, time_ns, segment_first, segment_last,
                  input ready);
  modport sink   (input valid, price_milli, time_ns, segment_first, segment_last,
                  output ready);
endinterface

interface rzt_out_if;
  import rzt_pkg::*;
  logic                        valid;
  logic                        ready;
  logic [TIME_W-1:0]           entry_time_ns;
  logic [TIME_W-1:0]           exit_time_ns;
  logic [PRICE_W-1:0]          open_price;
  logic [PRICE_W-1:0]          close_price;
  logic [QTY_W-1:0]            quantity;
  logic                        is_long;
  logic signed [PROFIT_W-1:0]  profit;
  modport source (output valid, entry_time_ns, exit_time_ns, open_price, close_price,
                  quantity, is_long, profit, input ready);
  modport sink   (input valid, entry_time_ns, exit_time_ns, open_price, close_price,
                  quantity, is_long, profit, output ready);
endinterface

### hdl/rolling_zscore_reversion_trader.sv
// Top level of the rolling z-score mean-reversion trader.
//
// Price records enter on in_if; a closed trade leaves on out_if. Both channels
// move a transaction at a rising edge where valid and ready are high. The
// configuration port writes one register per cycle with cfg_we_i, and is to be
// used only while no record is in flight.
//
// Each record is processed by a sequencer around one bit-serial multiplier and
// one bit-serial divider. Each product holds the sequencer until the multiplier
// is done, and these products set the rate at which records are taken. A flat
// window skips the z-score products, and an entry adds the quantity divide. A
// record is taken only when the sequencer is idle, so in_if.ready is low while a
// record is being worked on.
//
// A trade result sits in an output register until it is taken. If the receiver
// stalls, the next record is still accepted and processed; only a second trade
// waits for the first to drain. Reset returns the registers to their defaults,
// clears the window, drops any position and empties the output register. The
// price ring needs no clearing: a slot is only read once the current segment
// has written it.
module rolling_zscore_reversion_trader #(
  parameter int unsigned MAX_WINDOW = rzt_pkg::MAX_WINDOW_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [rzt_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [rzt_pkg::CFG_DATA_W-1:0]  cfg_wdata_i,
  rzt_in_if.sink                          in_if,
  rzt_out_if.source                       out_if
);
  import rzt_pkg::*;

  localparam int unsigned WW   = $clog2(MAX_WINDOW + 1);
  localparam int unsigned IW   = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
  localparam int unsigned SW   = PRICE_W + 1 + WW;
  localparam int unsigned QW   = 2 * PRICE_W + WW;
  localparam int unsigned DW   = 2 * PRICE_W + 2 * WW + 1;
  localparam int unsigned NW   = PRICE_W + 2 + WW;
  localparam int unsigned MA   = DW;
  localparam int unsigned MB   = (PRICE_W + 1 + WW > HOLD_W) ? PRICE_W + 1 + WW : HOLD_W;
  localparam int unsigned PW   = MA + MB;
  localparam int unsigned CNTW = $clog2(MB + 1);

  typedef enum logic [4:0] {
    ST_IDLE, ST_PREP, ST_RD, ST_XX, ST_OO, ST_WQ, ST_SS, ST_WX, ST_NN,
    ST_TT, ST_TD, ST_DEC, ST_HOLD, ST_PNL, ST_EMIT, ST_DIV
  } state_e;

  state_e state_q;

  // Configuration registers.
  logic [WLEN_W-1:0] wlen_q;
  logic [THR_W-1:0]  entry_thr_q, exit_thr_q;
  logic [HOLD_W-1:0] max_hold_q;

  // Current record.
  logic [PRICE_W-1:0] price_q;
  logic [TIME_W-1:0]  time_q;
  logic               last_q;

  // Window state.
  logic [WW-1:0]             w_q, slot_q, seen_q, slot_eff, slot_inc, seen_new;
  logic [PRICE_W-1:0]        base_q;
  logic signed [SW-1:0]      sum_q, sum_new;
  logic [QW-1:0]             sumsq_q, sumsq_new;
  logic signed [PRICE_W:0]   x_q, old_q;
  logic [PRICE_W-1:0]        abs_x, abs_old;
  logic [SW-2:0]             abs_sum;
  logic [2*PRICE_W-1:0]      xx_q;

  // Statistics.
  logic [DW-1:0]             wq_q, d_q, d_new;
  logic signed [NW-1:0]      n_q, n_new, wx_s;
  logic [PW-1:0]             nn_q, lhs;
  logic                      signal_q, ge_q, gt_q;

  // Position.
  logic                      pos_open_q, pos_long_q;
  logic [QTY_W-1:0]          qty_q;
  logic [TIME_W-1:0]         opened_at_q;
  logic [PRICE_W-1:0]        opened_price_q;
  logic signed [PRICE_W:0]   diff;
  logic [PRICE_W-1:0]        abs_diff;
  logic [TIME_W:0]           held_ns;
  logic                      held, zexit, pnl_neg;
  logic signed [PROFIT_W-1:0] pnl_q;

  // Output register.
  logic                       out_valid_q;
  logic [TIME_W-1:0]          o_entry_q, o_exit_q;
  logic [PRICE_W-1:0]         o_open_q, o_close_q;
  logic [QTY_W-1:0]           o_qty_q;
  logic                       o_long_q;
  logic signed [PROFIT_W-1:0] o_profit_q;

  // Shared arithmetic units.
  logic             mul_start_q, mul_done, div_start_q, div_done;
  logic             mul_go, div_go, can_open;
  logic [MA-1:0]    mul_a_q;
  logic [MB-1:0]    mul_b_q;
  logic [CNTW-1:0]  mul_n_q;
  logic [PW-1:0]    mul_p;
  logic [QTY_W-1:0] div_q;

  // Price ring memory.
  logic signed [PRICE_W:0] ring [MAX_WINDOW];
  logic signed [PRICE_W:0] ring_rd_q;
  logic                    ring_we;

  rzt_serial_mul #(.AW(MA), .BW(MB), .NW(CNTW)) u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mul_start_q),
    .a_i     (mul_a_q),
    .b_i     (mul_b_q),
    .nbits_i (mul_n_q),
    .done_o  (mul_done),
    .p_o     (mul_p)
  );

  rzt_serial_div u_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (div_start_q),
    .divisor_i (price_q),
    .done_o    (div_done),
    .quot_o    (div_q)
  );

  function automatic logic [WW-1:0] clamp_window(logic [WLEN_W-1:0] wl);
    if (wl == '0) begin
      return WW'(1);
    end else if (32'(wl) > MAX_WINDOW) begin
      return WW'(MAX_WINDOW);
    end else begin
      return WW'(wl);
    end
  endfunction

  // Combinational helpers.
  always_comb begin
    slot_eff  = (slot_q >= w_q) ? '0 : slot_q;
    slot_inc  = (slot_q + 1'b1 >= w_q) ? '0 : slot_q + 1'b1;
    seen_new  = (seen_q < w_q) ? seen_q + 1'b1 : seen_q;
    abs_x     = PRICE_W'(x_q[PRICE_W] ? -x_q : x_q);
    abs_old   = PRICE_W'(old_q[PRICE_W] ? -old_q : old_q);
    abs_sum   = (SW - 1)'(sum_q[SW-1] ? -sum_q : sum_q);
    if (seen_q >= w_q) begin
      sum_new   = sum_q - SW'(old_q) + SW'(x_q);
      sumsq_new = sumsq_q - QW'(mul_p[2*PRICE_W-1:0]) + QW'(xx_q);
    end else begin
      sum_new   = sum_q + SW'(x_q);
      sumsq_new = sumsq_q + QW'(xx_q);
    end
    d_new     = wq_q - mul_p[DW-1:0];
    wx_s      = $signed(mul_p[NW-1:0]);
    n_new     = (x_q[PRICE_W] ? -wx_s : wx_s) - NW'(sum_q);
    lhs       = nn_q << 16;
    diff      = $signed({1'b0, price_q}) - $signed({1'b0, opened_price_q});
    abs_diff  = PRICE_W'(diff[PRICE_W] ? -diff : diff);
    pnl_neg   = diff[PRICE_W] ^ ~pos_long_q;
    held_ns   = {1'b0, time_q} - {1'b0, opened_at_q};
    held      = (time_q >= opened_at_q) && (64'(held_ns) >= mul_p[63:0]);
    // A long closes once z has climbed back to the exit level, a short once it
    // has fallen to minus the exit level.
    zexit     = signal_q && ge_q && (pos_long_q ? !n_q[NW-1] : (n_q[NW-1] || n_q == '0));
    can_open  = signal_q && !last_q && gt_q && n_q != '0 &&
                price_q != '0 && price_q <= QTY_BUDGET;
  end

  // Start pulses for the shared units, one per product or divide.
  always_comb begin
    case (state_q)
      ST_RD:                              mul_go = 1'b1;
      ST_XX, ST_WQ, ST_WX, ST_NN, ST_TT:  mul_go = mul_done;
      ST_OO:                              mul_go = mul_done && (seen_new >= w_q);
      ST_SS:                              mul_go = mul_done && (d_new != '0);
      ST_DEC:                             mul_go = pos_open_q;
      ST_HOLD:                            mul_go = mul_done && (zexit || held || last_q);
      default:                            mul_go = 1'b0;
    endcase
    div_go = (state_q == ST_DEC) && !pos_open_q && can_open;
  end

  assign ring_we = (state_q == ST_OO) && mul_done;

  always_ff @(posedge clk_i) begin
    if (ring_we) begin
      ring[slot_q[IW-1:0]] <= x_q;
    end
    ring_rd_q <= ring[slot_eff[IW-1:0]];
  end

  assign in_if.ready = (state_q == ST_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= ST_IDLE;
      wlen_q         <= WINDOW_LENGTH_RST;
      entry_thr_q    <= ENTRY_THR_RST;
      exit_thr_q     <= EXIT_THR_RST;
      max_hold_q     <= MAX_HOLD_RST;
      price_q        <= '0;
      time_q         <= '0;
      last_q         <= 1'b0;
      w_q            <= clamp_window(WINDOW_LENGTH_RST);
      slot_q         <= '0;
      seen_q         <= '0;
      base_q         <= '0;
      sum_q          <= '0;
      sumsq_q        <= '0;
      x_q            <= '0;
      old_q          <= '0;
      xx_q           <= '0;
      wq_q           <= '0;
      d_q            <= '0;
      n_q            <= '0;
      nn_q           <= '0;
      signal_q       <= 1'b0;
      ge_q           <= 1'b0;
      gt_q           <= 1'b0;
      pos_open_q     <= 1'b0;
      pos_long_q     <= 1'b0;
      qty_q          <= '0;
      opened_at_q    <= '0;
      opened_price_q <= '0;
      pnl_q          <= '0;
      out_valid_q    <= 1'b0;
      o_entry_q      <= '0;
      o_exit_q       <= '0;
      o_open_q       <= '0;
      o_close_q      <= '0;
      o_qty_q        <= '0;
      o_long_q       <= 1'b0;
      o_profit_q     <= '0;
      mul_start_q    <= 1'b0;
      mul_a_q        <= '0;
      mul_b_q        <= '0;
      mul_n_q        <= '0;
      div_start_q    <= 1'b0;
    end else begin
      mul_start_q <= mul_go;
      div_start_q <= div_go;

      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_WINDOW_LENGTH: wlen_q      <= cfg_wdata_i[WLEN_W-1:0];
          CFG_ENTRY_THR:     entry_thr_q <= cfg_wdata_i[THR_W-1:0];
          CFG_EXIT_THR:      exit_thr_q  <= cfg_wdata_i[THR_W-1:0];
          CFG_MAX_HOLD:      max_hold_q  <= cfg_wdata_i[HOLD_W-1:0];
          default: ;
        endcase
      end

      // The emit state reloads the output register itself.
      if (out_valid_q && out_if.ready && state_q != ST_EMIT) begin
        out_valid_q <= 1'b0;
      end

      case (state_q)
        ST_IDLE: begin
          if (in_if.valid) begin
            price_q <= in_if.price_milli;
            time_q  <= in_if.time_ns;
            last_q  <= in_if.segment_last;
            // A new segment restarts the window and silently drops a position.
            if (in_if.segment_first) begin
              slot_q         <= '0;
              seen_q         <= '0;
              sum_q          <= '0;
              sumsq_q        <= '0;
              pos_open_q     <= 1'b0;
              pos_long_q     <= 1'b0;
              qty_q          <= '0;
              opened_at_q    <= '0;
              opened_price_q <= '0;
              base_q         <= in_if.price_milli;
              w_q            <= clamp_window(wlen_q);
            end
            state_q <= ST_PREP;
          end
        end
        ST_PREP: begin
          slot_q  <= slot_eff;
          x_q     <= $signed({1'b0, price_q}) - $signed({1'b0, base_q});
          state_q <= ST_RD;
        end
        ST_RD: begin
          old_q       <= ring_rd_q;
          mul_a_q     <= MA'(abs_x);
          mul_b_q     <= MB'(abs_x);
          mul_n_q     <= CNTW'(PRICE_W);
          state_q     <= ST_XX;
        end
        ST_XX: begin
          if (mul_done) begin
            xx_q        <= mul_p[2*PRICE_W-1:0];
            mul_a_q     <= MA'(abs_old);
            mul_b_q     <= MB'(abs_old);
            mul_n_q     <= CNTW'(PRICE_W);
            state_q     <= ST_OO;
          end
        end
        ST_OO: begin
          if (mul_done) begin
            sum_q   <= sum_new;
            sumsq_q <= sumsq_new;
            slot_q  <= slot_inc;
            seen_q  <= seen_new;
            if (seen_new >= w_q) begin
              mul_a_q     <= MA'(sumsq_new);
              mul_b_q     <= MB'(w_q);
              mul_n_q     <= CNTW'(WW);
              state_q     <= ST_WQ;
            end else begin
              signal_q <= 1'b0;
              state_q  <= ST_DEC;
            end
          end
        end
        ST_WQ: begin
          if (mul_done) begin
            wq_q        <= mul_p[DW-1:0];
            mul_a_q     <= MA'(abs_sum);
            mul_b_q     <= MB'(abs_sum);
            mul_n_q     <= CNTW'(SW - 1);
            state_q     <= ST_SS;
          end
        end
        ST_SS: begin
          if (mul_done) begin
            d_q <= d_new;
            // A flat window has no variance and gives no signal.
            if (d_new == '0) begin
              signal_q <= 1'b0;
              state_q  <= ST_DEC;
            end else begin
              signal_q    <= 1'b1;
              mul_a_q     <= MA'(abs_x);
              mul_b_q     <= MB'(w_q);
              mul_n_q     <= CNTW'(WW);
              state_q     <= ST_WX;
            end
          end
        end
        ST_WX: begin
          if (mul_done) begin
            n_q         <= n_new;
            mul_a_q     <= MA'((NW - 1)'(n_new[NW-1] ? -n_new : n_new));
            mul_b_q     <= MB'((NW - 1)'(n_new[NW-1] ? -n_new : n_new));
            mul_n_q     <= CNTW'(NW - 1);
            state_q     <= ST_NN;
          end
        end
        ST_NN: begin
          if (mul_done) begin
            nn_q        <= mul_p;
            mul_a_q     <= MA'(pos_open_q ? exit_thr_q : entry_thr_q);
            mul_b_q     <= MB'(pos_open_q ? exit_thr_q : entry_thr_q);
            mul_n_q     <= CNTW'(THR_W);
            state_q     <= ST_TT;
          end
        end
        ST_TT: begin
          if (mul_done) begin
            mul_a_q     <= MA'(d_q);
            mul_b_q     <= MB'(mul_p[2*THR_W-1:0]);
            mul_n_q     <= CNTW'(2 * THR_W);
            state_q     <= ST_TD;
          end
        end
        ST_TD: begin
          // Squared z against the squared Q8.8 threshold, both scaled to Q16.16.
          if (mul_done) begin
            ge_q    <= (lhs >= mul_p);
            gt_q    <= (lhs > mul_p);
            state_q <= ST_DEC;
          end
        end
        ST_DEC: begin
          if (pos_open_q) begin
            mul_a_q     <= MA'(max_hold_q);
            mul_b_q     <= MB'(NS_PER_S);
            mul_n_q     <= CNTW'(NS_W);
            state_q     <= ST_HOLD;
          end else if (can_open) begin
            state_q     <= ST_DIV;
          end else begin
            state_q <= ST_IDLE;
          end
        end
        ST_HOLD: begin
          if (mul_done) begin
            if (zexit || held || last_q) begin
              mul_a_q     <= MA'(abs_diff);
              mul_b_q     <= MB'(qty_q);
              mul_n_q     <= CNTW'(QTY_W);
              state_q     <= ST_PNL;
            end else begin
              state_q <= ST_IDLE;
            end
          end
        end
        ST_PNL: begin
          if (mul_done) begin
            pnl_q   <= pnl_neg ? -$signed(mul_p[PROFIT_W-1:0])
                               : $signed(mul_p[PROFIT_W-1:0]);
            state_q <= ST_EMIT;
          end
        end
        ST_EMIT: begin
          // Wait only if an earlier trade is still held by the receiver.
          if (!out_valid_q || out_if.ready) begin
            out_valid_q <= 1'b1;
            o_entry_q   <= opened_at_q;
            o_exit_q    <= time_q;
            o_open_q    <= opened_price_q;
            o_close_q   <= price_q;
            o_qty_q     <= qty_q;
            o_long_q    <= pos_long_q;
            o_profit_q  <= pnl_q;
            pos_open_q  <= 1'b0;
            state_q     <= ST_IDLE;
          end
        end
        ST_DIV: begin
          if (div_done) begin
            pos_open_q     <= 1'b1;
            pos_long_q     <= n_q[NW-1];
            qty_q          <= div_q;
            opened_at_q    <= time_q;
            opened_price_q <= price_q;
            state_q        <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign out_if.valid         = out_valid_q;
  assign out_if.entry_time_ns = o_entry_q;
  assign out_if.exit_time_ns  = o_exit_q;
  assign out_if.open_price    = o_open_q;
  assign out_if.close_price   = o_close_q;
  assign out_if.quantity      = o_qty_q;
  assign out_if.is_long       = o_long_q;
  assign out_if.profit        = o_profit_q;

endmodule

### hdl/rzt_serial_mul.sv
// Bit-serial shift-and-add multiplier, one multiplier bit per cycle.
module rzt_serial_mul #(
  parameter int unsigned AW = 64,
  parameter int unsigned BW = 32,
  parameter int unsigned NW = $clog2(BW + 1)
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic [AW-1:0]      a_i,
  input  logic [BW-1:0]      b_i,
  input  logic [NW-1:0]      nbits_i,
  output logic               done_o,
  output logic [AW+BW-1:0]   p_o
);
  logic [AW+BW-1:0] a_q, acc_q;
  logic [BW-1:0]    b_q;
  logic [NW-1:0]    cnt_q;
  logic             busy_q, done_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_q    <= '0;
      acc_q  <= '0;
      b_q    <= '0;
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else if (start_i) begin
      a_q    <= (AW + BW)'(a_i);
      b_q    <= b_i;
      acc_q  <= '0;
      cnt_q  <= nbits_i;
      busy_q <= 1'b1;
      done_q <= 1'b0;
    end else if (busy_q) begin
      if (b_q[0]) begin
        acc_q <= acc_q + a_q;
      end
      a_q   <= a_q << 1;
      b_q   <= b_q >> 1;
      cnt_q <= cnt_q - 1'b1;
      if (cnt_q == NW'(1)) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end else begin
      done_q <= 1'b0;
    end
  end

  assign done_o = done_q;
  assign p_o    = acc_q;
endmodule

### hdl/rzt_serial_div.sv
// Restoring divider of the fixed share budget by the price, one quotient bit per cycle.
module rzt_serial_div (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic [rzt_pkg::PRICE_W-1:0]  divisor_i,
  output logic                         done_o,
  output logic [rzt_pkg::QTY_W-1:0]    quot_o
);
  import rzt_pkg::*;
  localparam int unsigned CW = $clog2(PRICE_W + 1);

  logic [PRICE_W:0]   rem_q;
  logic [PRICE_W:0]   rem_sh;
  logic [PRICE_W-1:0] dvd_q, dvs_q;
  logic [QTY_W-1:0]   quot_q;
  logic [CW-1:0]      cnt_q;
  logic               busy_q, done_q;

  assign rem_sh = {rem_q[PRICE_W-1:0], dvd_q[PRICE_W-1]};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rem_q  <= '0;
      dvd_q  <= '0;
      dvs_q  <= '0;
      quot_q <= '0;
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else if (start_i) begin
      rem_q  <= '0;
      dvd_q  <= QTY_BUDGET;
      dvs_q  <= divisor_i;
      quot_q <= '0;
      cnt_q  <= CW'(PRICE_W);
      busy_q <= 1'b1;
      done_q <= 1'b0;
    end else if (busy_q) begin
      dvd_q <= dvd_q << 1;
      if (rem_sh >= {1'b0, dvs_q}) begin
        rem_q  <= rem_sh - {1'b0, dvs_q};
        quot_q <= {quot_q[QTY_W-2:0], 1'b1};
      end else begin
        rem_q  <= rem_sh;
        quot_q <= {quot_q[QTY_W-2:0], 1'b0};
      end
      cnt_q <= cnt_q - 1'b1;
      if (cnt_q == CW'(1)) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end else begin
      done_q <= 1'b0;
    end
  end

  assign done_o = done_q;
  assign quot_o = quot_q;
endmodule

### sim/rolling_zscore_reversion_trader_tb.sv
// Self-checking testbench for the rolling z-score mean-reversion trader.
`timescale 1ns / 1ps

module rolling_zscore_reversion_trader_tb;
  import rzt_pkg::*;

  // One closed trade, as the block reports it.
  typedef struct {
    logic [TIME_W-1:0]          entry_t;
    logic [TIME_W-1:0]          exit_t;
    logic [PRICE_W-1:0]         open_px;
    logic [PRICE_W-1:0]         close_px;
    logic [QTY_W-1:0]           qty;
    logic                       long_side;
    logic signed [PROFIT_W-1:0] pnl;
  } trade_t;

  // The scoreboard carries its own copy of the trading state and predicts the trade
  // that each accepted record closes, if any.
  class trade_scoreboard;
    trade_t       trades_due[$];
    int           mismatches;
    logic [8:0]   wlen_reg;
    logic [15:0]  entry_reg;
    logic [15:0]  exit_reg;
    logic [31:0]  hold_reg;
    longint       ring[MAX_WINDOW_DEF];
    int unsigned  slot;
    int unsigned  seen;
    int unsigned  win;
    logic [23:0]  base_px;
    longint       run_sum;
    logic [63:0]  run_sq;
    bit           in_trade;
    bit           trade_long;
    logic [23:0]  trade_qty;
    logic [63:0]  trade_at;
    logic [23:0]  trade_px;

    function new();
      mismatches = 0;
      wlen_reg = WINDOW_LENGTH_RST;
      entry_reg = ENTRY_THR_RST;
      exit_reg = EXIT_THR_RST;
      hold_reg = MAX_HOLD_RST;
      base_px = '0;
      win = 20;
      drop_segment();
    endfunction

    function void drop_segment();
      foreach (ring[i]) ring[i] = 0;
      slot = 0;
      seen = 0;
      run_sum = 0;
      run_sq = '0;
      in_trade = 0;
      trade_long = 0;
      trade_qty = '0;
      trade_at = '0;
      trade_px = '0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
      case (idx)
        CFG_WINDOW_LENGTH: wlen_reg = val[8:0];
        CFG_ENTRY_THR:     entry_reg = val[15:0];
        CFG_EXIT_THR:      exit_reg = val[15:0];
        CFG_MAX_HOLD:      hold_reg = val;
        default: ;
      endcase
    endfunction

    function logic [63:0] mag(longint v);
      return (v < 0) ? 64'(-v) : 64'(v);
    endfunction

    // Sign of 65536*N*N - thr*thr*D, in 128-bit arithmetic with no square root.
    function int zscore_vs(logic [63:0] absn, logic [127:0] dv, logic [15:0] thr);
      logic [127:0] lhs;
      logic [127:0] rhs;
      lhs = ({64'b0, absn} * {64'b0, absn}) << 16;
      rhs = dv * {64'b0, 64'(thr) * 64'(thr)};
      if (lhs > rhs) return 1;
      if (lhs < rhs) return -1;
      return 0;
    endfunction

    function void note_record(logic [23:0] price, logic [62:0] t, bit first, bit last);
      longint       x;
      longint       old;
      longint       n;
      longint       pl;
      logic [63:0]  as;
      logic [127:0] dv;
      logic [63:0]  hold_ns;
      bit           sig;
      bit           zexit;
      bit           held;
      int           c;
      trade_t       tr;
      if (first) begin
        drop_segment();
        base_px = price;
        win = (wlen_reg == 0) ? 1 : (wlen_reg > MAX_WINDOW_DEF) ? MAX_WINDOW_DEF : wlen_reg;
      end
      if (slot >= win) slot = 0;
      x = longint'({40'b0, price}) - longint'({40'b0, base_px});
      if (seen >= win) begin
        old = ring[slot];
        run_sum -= old;
        run_sq -= 64'(old * old);
      end
      ring[slot] = x;
      run_sum += x;
      run_sq += 64'(x * x);
      slot++;
      if (slot >= win) slot = 0;
      if (seen < win) seen++;
      sig = 0;
      n = 0;
      dv = '0;
      if (seen >= win) begin
        as = mag(run_sum);
        dv = {64'b0, 64'(win)} * {64'b0, run_sq} - {64'b0, as} * {64'b0, as};
        if (dv != 0) begin
          sig = 1;
          n = longint'(win) * x - run_sum;
        end
      end
      if (in_trade) begin
        zexit = 0;
        hold_ns = 64'(hold_reg) * 64'd1000000000;
        if (sig) begin
          c = zscore_vs(mag(n), dv, exit_reg);
          zexit = trade_long ? (n >= 0 && c >= 0) : (n <= 0 && c >= 0);
        end
        held = ({1'b0, t} >= trade_at) && ({1'b0, t} - trade_at >= hold_ns);
        if (zexit || held || last) begin
          pl = longint'({40'b0, trade_qty}) *
               (longint'({40'b0, price}) - longint'({40'b0, trade_px}));
          if (!trade_long) pl = -pl;
          tr.entry_t = trade_at[62:0];
          tr.exit_t = t;
          tr.open_px = trade_px;
          tr.close_px = price;
          tr.qty = trade_qty;
          tr.long_side = trade_long;
          tr.pnl = pl;
          trades_due.insert(trades_due.size(), tr);
          in_trade = 0;
        end
      end else if (sig && !last) begin
        c = zscore_vs(mag(n), dv, entry_reg);
        if (n != 0 && c > 0 && price != 0 && price <= 24'd10000000) begin
          in_trade = 1;
          trade_long = (n < 0);
          trade_qty = 24'd10000000 / price;
          trade_at = {1'b0, t};
          trade_px = price;
        end
      end
    endfunction

    function void check_trade(trade_t got);
      trade_t want;
      if (trades_due.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: unexpected trade, entry %0d exit %0d pnl %0d", $realtime,
                   got.entry_t, got.exit_t, got.pnl);
        return;
      end
      want = trades_due.pop_front();
      if (got.entry_t !== want.entry_t || got.exit_t !== want.exit_t ||
          got.open_px !== want.open_px || got.close_px !== want.close_px ||
          got.qty !== want.qty || got.long_side !== want.long_side ||
          got.pnl !== want.pnl) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("%0t: trade mismatch", $realtime);
          $display("  expected entry %0d exit %0d open %0d close %0d qty %0d long %0b pnl %0d",
                   want.entry_t, want.exit_t, want.open_px, want.close_px, want.qty,
                   want.long_side, want.pnl);
          $display("  actual   entry %0d exit %0d open %0d close %0d qty %0d long %0b pnl %0d",
                   got.entry_t, got.exit_t, got.open_px, got.close_px, got.qty,
                   got.long_side, got.pnl);
        end
      end
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx_i = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata_i = '0;

  rzt_in_if  in_if ();
  rzt_out_if out_if ();

  rolling_zscore_reversion_trader uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_if       (in_if.sink),
    .out_if      (out_if.source)
  );

  always #5 clk_i = ~clk_i;

  trade_scoreboard trades = new();

  // Steady flag: no idling on either side. Hold-off request: the receiver stalls long.
  bit          steady = 0;
  bit          hold_off_req = 0;
  logic [62:0] now_t = '0;
  int          records_sent = 0;

  // Gap lengths: mostly none or short, now and then a long one.
  function int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (steady || r < 65) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  // Receiver: random ready with gaps, plus one long counted hold-off on request.
  initial begin
    int low_left;
    low_left = 0;
    out_if.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_off_req) begin
        out_if.ready = 1'b0;
        repeat (3000) @(negedge clk_i);
        hold_off_req = 0;
      end else if (low_left > 0) begin
        out_if.ready = 1'b0;
        low_left--;
      end else begin
        out_if.ready = 1'b1;
        if ($urandom_range(0, 5) == 0) low_left = pick_gap();
      end
    end
  end

  // Every trade transaction is checked at the edge that moves it.
  always @(posedge clk_i) begin
    trade_t got;
    if (rst_ni && out_if.valid && out_if.ready) begin
      got.entry_t = out_if.entry_time_ns;
      got.exit_t = out_if.exit_time_ns;
      got.open_px = out_if.open_price;
      got.close_px = out_if.close_price;
      got.qty = out_if.quantity;
      got.long_side = out_if.is_long;
      got.pnl = out_if.profit;
      trades.check_trade(got);
    end
  end

  // Offers one record, waits for its transaction, then tells the scoreboard.
  task automatic send_record(logic [23:0] price, logic [62:0] t, bit first, bit last);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_if.valid = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_if.price_milli = price;
    in_if.time_ns = t;
    in_if.segment_first = first;
    in_if.segment_last = last;
    in_if.valid = 1'b1;
    do @(posedge clk_i); while (!in_if.ready);
    trades.note_record(price, t, first, last);
    records_sent++;
    @(negedge clk_i);
  endtask

  // Registers change only with the block idle: all trades drained and the
  // record in flight finished.
  task automatic settle();
    in_if.valid = 1'b0;
    wait (trades.trades_due.size() == 0);
    @(negedge clk_i);
    repeat (400) @(negedge clk_i);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    cfg_idx_i = idx;
    cfg_wdata_i = val;
    cfg_we_i = 1'b1;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
    trades.write_reg(idx, val);
  endtask

  task automatic set_regs(logic [8:0] wl, logic [15:0] ent, logic [15:0] ext, logic [31:0] hs);
    settle();
    write_reg(CFG_WINDOW_LENGTH, CFG_DATA_W'(wl));
    write_reg(CFG_ENTRY_THR, CFG_DATA_W'(ent));
    write_reg(CFG_EXIT_THR, CFG_DATA_W'(ext));
    write_reg(CFG_MAX_HOLD, hs);
  endtask

  // Moves the clock a few seconds on, sometimes backwards or to a random point.
  task automatic step_time();
    int r;
    r = $urandom_range(0, 99);
    if (r < 3) now_t = 63'({$urandom, $urandom});
    else if (r < 6 && now_t > 63'd10000000000)
      now_t = now_t - 63'($urandom_range(1, 2000000000));
    else now_t = now_t + 63'($urandom_range(1, 4)) * 63'd1000000000 +
                 63'($urandom_range(0, 999));
  endtask

  // One segment that hovers around a base price, with jumps that drive the z-score
  // past the thresholds, and a little noise in the segment marks.
  task automatic run_segment(int len);
    logic [23:0] base;
    longint      px;
    int          r;
    bit          fm;
    bit          lm;
    base = ($urandom_range(0, 9) == 0) ? 24'($urandom) : 24'($urandom_range(1000, 300000));
    for (int i = 0; i < len; i++) begin
      r = $urandom_range(0, 99);
      if (r < 2) px = 0;
      else if (r < 4) px = longint'($urandom_range(0, 24'hFFFFFF));
      else if (r < 16) px = longint'(base) + $signed($urandom_range(0, 4000)) - 2000;
      else px = longint'(base) + $signed($urandom_range(0, 200)) - 100;
      if (px < 0) px = 0;
      if (px > 24'hFFFFFF) px = 24'hFFFFFF;
      fm = (i == 0) || ($urandom_range(0, 79) == 0);
      lm = (i == len - 1) || ($urandom_range(0, 59) == 0);
      step_time();
      send_record(24'(px), now_t, fm, lm);
    end
  endtask

  task automatic run_phase(int items, int wmin, int wmax);
    int stop;
    int w;
    stop = records_sent + items;
    while (records_sent < stop) begin
      w = $urandom_range(wmin, wmax);
      run_segment(w + $urandom_range(2, 3 * w + 12));
    end
  endtask

  initial begin
    in_if.valid = 1'b0;
    in_if.price_milli = '0;
    in_if.time_ns = '0;
    in_if.segment_first = 1'b0;
    in_if.segment_last = 1'b0;
    repeat (3) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Directed part. A two-price window always yields |z| = 1 when the prices
    // differ, so when flat a zero entry threshold opens on every tradable move.
    set_regs(9'd2, 16'd0, 16'd0, 32'd1);
    send_record(24'd100, 63'd0, 0, 0);            // before any segment start
    send_record(24'd200, 63'd1, 0, 0);            // window still at the reset length: no signal
    send_record(24'd0, 63'd5, 1, 0);              // segment start applies the window length of two
    send_record(24'hFFFFFF, 63'd6, 0, 0);         // price too high for a unit of quantity
    send_record(24'd0, 63'd7, 0, 0);              // zero price blocks a long
    send_record(24'd5, 63'd8, 0, 0);              // opens a short
    send_record(24'd5, 63'd3, 0, 0);              // time goes backwards, flat window
    send_record(24'd1, 63'd9, 0, 1);              // segment end forces the exit
    send_record(24'd7, {63{1'b1}}, 1, 1);         // one-record segment
    send_record(24'd10, {63{1'b1}} - 63'd10, 1, 0);
    send_record(24'd20, {63{1'b1}} - 63'd5, 0, 0);
    send_record(24'd30, {63{1'b1}}, 0, 0);
    send_record(24'd10, {63{1'b1}}, 0, 0);        // reversal closes the short
    send_record(24'd10000000, 63'd100, 1, 0);
    send_record(24'd9999999, 63'd1000000100, 0, 0); // opens a long, quantity 1
    send_record(24'd10000000, 63'd2000000100, 0, 0); // hold time expires
    send_record(24'd3, 63'd0, 1, 0);
    send_record(24'd2, 63'd1, 0, 0);
    send_record(24'd2, 63'd5000000000, 0, 1);

    // Window length zero is taken as one: never a signal.
    set_regs(9'd0, 16'd0, 16'd0, 32'd0);
    send_record(24'd50, 63'd10, 1, 0);
    send_record(24'd80, 63'd11, 0, 0);
    send_record(24'd20, 63'd12, 0, 1);

    // Random part over several settings.
    set_regs(9'd4, 16'd256, 16'd64, 32'd60);
    run_phase(80, 4, 4);
    set_regs(9'd8, 16'd128, 16'd0, 32'd5);
    steady = 1;
    hold_off_req = 1;
    run_phase(70, 8, 8);
    steady = 0;
    set_regs(9'd3, 16'd0, 16'hFFFF, 32'd0);
    run_phase(70, 3, 3);
    set_regs(9'd16, 16'hFFFF, 16'd128, 32'd2);
    run_phase(60, 16, 16);
    set_regs(9'd5, 16'd200, 16'd50, 32'hFFFFFFFF);
    run_phase(80, 5, 5);
    set_regs(9'd511, 16'd300, 16'd100, 32'd20);
    run_segment(270);
    set_regs(9'd6, 16'd350, 16'd30, 32'd8);
    run_phase(70, 6, 6);

    settle();
    if (trades.mismatches == 0 && trades.trades_due.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  initial begin
    #50ms;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule

### filelist.f
hdl/rzt_pkg.sv
hdl/rzt_stream_if.sv
hdl/rzt_serial_mul.sv
hdl/rzt_serial_div.sv
hdl/rolling_zscore_reversion_trader.sv
sim/rolling_zscore_reversion_trader_tb.sv
